// ===== rtl/core/direct_mapped_read_cache_macros.svh =====
`ifndef DIRECT_MAPPED_READ_CACHE_MACROS_SVH
`define DIRECT_MAPPED_READ_CACHE_MACROS_SVH

// same-cycle implication, clocked on clk, idle while arst_n is low
`define DMC_ASSERT_IMM(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dmc assertion failed");

// next-cycle implication, clocked on clk, idle while arst_n is low
`define DMC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dmc assertion failed");

`endif

// ===== rtl/core/dmc_pkg.sv =====
package dmc_pkg;

	localparam int ADDR_W   = 32;
	localparam int WORD_W   = 64;
	localparam int FIDX_W   = 2;
	localparam int KIND_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int CNT_W    = 32;
	localparam int WORD_BYTES = 8;
	localparam int BSEL_W   = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_HIT       = 2'd0,
		KIND_MISS      = 2'd1,
		KIND_FILL_DONE = 2'd2,
		KIND_FILL_ACK  = 2'd3
	} kind_t;

	typedef enum logic {
		OP_READ = 1'b0,
		OP_FILL = 1'b1
	} op_t;

endpackage

// ===== rtl/core/dmc_req_if.sv =====
interface dmc_req_if;
	logic                             valid;
	logic                             ready;
	logic                             op;
	logic [dmc_pkg::ADDR_W-1:0]       address;
	logic [dmc_pkg::WORD_W-1:0]       fill_word;
	logic [dmc_pkg::FIDX_W-1:0]       fill_index;

	modport source (output valid, output op, output address, output fill_word,
		output fill_index, input ready);
	modport sink (input valid, input op, input address, input fill_word,
		input fill_index, output ready);
endinterface

// ===== rtl/core/dmc_rsp_if.sv =====
interface dmc_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [dmc_pkg::KIND_W-1:0]       kind;
	logic [dmc_pkg::BYTE_W-1:0]       data_byte;
	logic [dmc_pkg::ADDR_W-1:0]       line_address;
	logic [dmc_pkg::CNT_W-1:0]        hits_so_far;
	logic [dmc_pkg::CNT_W-1:0]        misses_so_far;

	modport source (output valid, output kind, output data_byte, output line_address,
		output hits_so_far, output misses_so_far, input ready);
	modport sink (input valid, input kind, input data_byte, input line_address,
		input hits_so_far, input misses_so_far, output ready);
endinterface

// ===== rtl/core/dmc_ram.sv =====
module dmc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/direct_mapped_read_cache.sv =====
// A request's result is registered in the memory read stage and then in the result register.
// Throughput: one item per cycle while the result is not stalled; the tag and line-data memories each
// take one read and one write per cycle, and a stalled result stalls the request side.
// Reset: arst_n clears valid bits, counters, pending offset and pipeline valids at once;
// tag and line-data memories are not cleared and no clearing pass is run.
module direct_mapped_read_cache #(
	parameter int NUM_SETS   = 8,
	parameter int LINE_BYTES = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	dmc_req_if.sink   req,
	dmc_rsp_if.source rsp
);

	`include "direct_mapped_read_cache_macros.svh"

	localparam int WPL  = LINE_BYTES / dmc_pkg::WORD_BYTES;
	localparam int OFFW = $clog2(LINE_BYTES);
	localparam int SETW = $clog2(NUM_SETS);
	localparam int TAGW = dmc_pkg::ADDR_W - OFFW - SETW;
	localparam int WSH  = $clog2(WPL);
	localparam int WIDX = (WPL > 1) ? WSH : 1;
	localparam int DEPTH = NUM_SETS * WPL;
	localparam int DAW  = $clog2(DEPTH);

	logic            advance;
	logic            acc;
	logic [OFFW-1:0] offset;
	logic [SETW-1:0] set;
	logic [TAGW-1:0] tag;
	logic [WIDX-1:0] fidx;
	logic            fill_last;
	logic [OFFW-1:0] sel_off;
	logic [WIDX-1:0] sel_word;
	logic [DAW-1:0]  rd_addr;
	logic [DAW-1:0]  wr_addr;

	logic [NUM_SETS-1:0] valid_q;
	logic [OFFW-1:0]     pend_q;

	logic                        vld_s1;
	dmc_pkg::op_t                op_s1;
	logic                        last_s1;
	logic                        fwd_s1;
	logic [dmc_pkg::BSEL_W-1:0]  bsel_s1;
	logic [TAGW-1:0]             tag_s1;
	logic                        lvalid_s1;
	logic [dmc_pkg::WORD_W-1:0]  fword_s1;
	logic [dmc_pkg::ADDR_W-1:0]  laddr_s1;

	logic [TAGW-1:0]            tag_rdata;
	logic [dmc_pkg::WORD_W-1:0] data_rdata;

	logic                       hit;
	logic [dmc_pkg::WORD_W-1:0] line_word;
	logic [dmc_pkg::BYTE_W-1:0] sel_byte;
	dmc_pkg::kind_t             kind_d;

	logic                       out_vld_q;
	dmc_pkg::kind_t             kind_q;
	logic [dmc_pkg::BYTE_W-1:0] byte_q;
	logic [dmc_pkg::ADDR_W-1:0] laddr_q;
	logic [dmc_pkg::CNT_W-1:0]  hit_cnt_q;
	logic [dmc_pkg::CNT_W-1:0]  miss_cnt_q;

	assign advance   = !out_vld_q || rsp.ready;
	assign req.ready = advance;
	assign acc       = req.valid && advance;

	assign offset = req.address[OFFW-1:0];
	assign set    = req.address[OFFW +: SETW];
	assign tag    = req.address[dmc_pkg::ADDR_W-1 -: TAGW];
	assign fidx   = (WPL == 1) ? '0 : WIDX'(req.fill_index);
	assign fill_last = (fidx == WIDX'(WPL - 1));

	assign sel_off  = (req.op == dmc_pkg::OP_FILL) ? pend_q : offset;
	assign sel_word = WIDX'(sel_off >> dmc_pkg::BSEL_W);
	assign rd_addr  = (DAW'(set) << WSH) | DAW'(sel_word);
	assign wr_addr  = (DAW'(set) << WSH) | DAW'(fidx);

	dmc_ram #(
		.WIDTH (TAGW),
		.DEPTH (NUM_SETS)
	) u_tag_ram (
		.clk   (clk),
		.we    (acc && req.op == dmc_pkg::OP_FILL && fill_last),
		.waddr (set),
		.wdata (tag),
		.re    (acc),
		.raddr (set),
		.rdata (tag_rdata)
	);

	dmc_ram #(
		.WIDTH (dmc_pkg::WORD_W),
		.DEPTH (DEPTH)
	) u_data_ram (
		.clk   (clk),
		.we    (acc && req.op == dmc_pkg::OP_FILL),
		.waddr (wr_addr),
		.wdata (req.fill_word),
		.re    (acc),
		.raddr (rd_addr),
		.rdata (data_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			pend_q  <= '0;
		end else if (acc) begin
			if (req.op == dmc_pkg::OP_READ) begin
				pend_q <= offset;
			end else if (fill_last) begin
				valid_q[set] <= 1'b1;
			end else if (fidx == '0) begin
				valid_q[set] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1     <= dmc_pkg::op_t'(req.op);
			last_s1   <= fill_last;
			fwd_s1    <= (sel_word == fidx);
			bsel_s1   <= sel_off[dmc_pkg::BSEL_W-1:0];
			tag_s1    <= tag;
			lvalid_s1 <= valid_q[set];
			fword_s1  <= req.fill_word;
			laddr_s1  <= {req.address[dmc_pkg::ADDR_W-1:OFFW], OFFW'(0)};
		end
	end

	// forward the fill word when the pending byte sits in the word being written
	assign hit       = lvalid_s1 && (tag_rdata == tag_s1);
	assign line_word = (op_s1 == dmc_pkg::OP_FILL && fwd_s1) ? fword_s1 : data_rdata;
	assign sel_byte  = line_word[{bsel_s1, 3'b000} +: dmc_pkg::BYTE_W];

	always_comb begin
		if (op_s1 == dmc_pkg::OP_READ) begin
			kind_d = hit ? dmc_pkg::KIND_HIT : dmc_pkg::KIND_MISS;
		end else begin
			kind_d = last_s1 ? dmc_pkg::KIND_FILL_DONE : dmc_pkg::KIND_FILL_ACK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (advance) begin
			out_vld_q <= vld_s1;
			if (vld_s1 && kind_d == dmc_pkg::KIND_HIT) begin
				hit_cnt_q <= hit_cnt_q + 1'b1;
			end
			if (vld_s1 && kind_d == dmc_pkg::KIND_MISS) begin
				miss_cnt_q <= miss_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			kind_q  <= kind_d;
			byte_q  <= (kind_d == dmc_pkg::KIND_HIT || kind_d == dmc_pkg::KIND_FILL_DONE)
				? sel_byte : '0;
			laddr_q <= (kind_d == dmc_pkg::KIND_MISS) ? laddr_s1 : '0;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.kind          = kind_q;
	assign rsp.data_byte     = byte_q;
	assign rsp.line_address  = laddr_q;
	assign rsp.hits_so_far   = hit_cnt_q;
	assign rsp.misses_so_far = miss_cnt_q;

	`DMC_ASSERT_NXT(a_s1_hold, vld_s1 && !advance, vld_s1)
	`DMC_ASSERT_NXT(a_miss_count, advance && vld_s1 && op_s1 == dmc_pkg::OP_READ && !hit,
		miss_cnt_q == $past(miss_cnt_q) + 1'b1 && hit_cnt_q == $past(hit_cnt_q))
	`DMC_ASSERT_IMM(a_miss_no_data, out_vld_q && kind_q == dmc_pkg::KIND_MISS, byte_q == '0)
	`DMC_ASSERT_IMM(a_laddr_miss_only, out_vld_q && kind_q != dmc_pkg::KIND_MISS,
		laddr_q == '0)

endmodule
